### design/macd_indicator_stream_defines.svh
// Assertion macros shared by the MACD stream checker.
`ifndef MACD_INDICATOR_STREAM_DEFINES_SVH
`define MACD_INDICATOR_STREAM_DEFINES_SVH

// Clocked assertion, quiet while reset is high.
`define MACD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Clocked assertion that also holds across reset.
`define MACD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### design/macd_pkg.sv
// Constants, types and helpers for the MACD indicator stream.
package macd_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int PRICE_BITS = 32;

   localparam int FACTOR_W = FRAC_BITS + 1;
   localparam int X_W      = PRICE_BITS + FRAC_BITS;
   localparam int LINE_W   = X_W + 1;
   localparam int HIST_W   = LINE_W + 1;
   localparam int DIFF_W   = LINE_W + 1;
   localparam int MUL_W    = DIFF_W + FACTOR_W + 1;

   localparam int REQ_DATA_W = ((PRICE_BITS + 7) / 8) * 8;
   localparam int RSP_BITS   = 2 * LINE_W + HIST_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [FACTOR_W-1:0] FACTOR_ONE = FACTOR_W'(1) << FRAC_BITS;

   localparam logic [FACTOR_W-1:0] SHORT_FACTOR_RST  = FACTOR_W'(10082);
   localparam logic [FACTOR_W-1:0] LONG_FACTOR_RST   = FACTOR_W'(4855);
   localparam logic [FACTOR_W-1:0] SIGNAL_FACTOR_RST = FACTOR_W'(13107);

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_FACTOR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_FACTOR   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIGNAL_FACTOR = 2'd2;

   // EMA selector used for operand loads and accumulator updates
   localparam logic [1:0] SEL_NONE   = 2'd0;
   localparam logic [1:0] SEL_SHORT  = 2'd1;
   localparam logic [1:0] SEL_LONG   = 2'd2;
   localparam logic [1:0] SEL_SIGNAL = 2'd3;

   typedef struct packed {
      logic       capture;
      logic [1:0] load_sel;
      logic [1:0] upd_sel;
      logic       macd_load;
      logic       out_load;
   } macd_cmd_type;

   // A factor above one acts as exactly one.
   function automatic logic [FACTOR_W-1:0] sat_factor(input logic [FACTOR_W-1:0] f);
      logic [FACTOR_W-1:0] r;
      r = (f > FACTOR_ONE) ? FACTOR_ONE : f;
      return r;
   endfunction

endpackage

### design/macd_ctrl.sv
// Sequencer for the MACD stream: steps one item through the shared multiplier.
module macd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output macd_pkg::macd_cmd_type cmd
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_LOAD_S = 4'd1;
   localparam logic [3:0] ST_LOAD_L = 4'd2;
   localparam logic [3:0] ST_UPD_S  = 4'd3;
   localparam logic [3:0] ST_UPD_L  = 4'd4;
   localparam logic [3:0] ST_MACD   = 4'd5;
   localparam logic [3:0] ST_LOAD_G = 4'd6;
   localparam logic [3:0] ST_MUL_G  = 4'd7;
   localparam logic [3:0] ST_UPD_G  = 4'd8;
   localparam logic [3:0] ST_OUT    = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      cmd.capture   = 1'b0;
      cmd.load_sel  = macd_pkg::SEL_NONE;
      cmd.upd_sel   = macd_pkg::SEL_NONE;
      cmd.macd_load = 1'b0;
      cmd.out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOAD_S;
            end
         end
         ST_LOAD_S: begin
            cmd.load_sel = macd_pkg::SEL_SHORT;
            state_in     = ST_LOAD_L;
         end
         ST_LOAD_L: begin
            cmd.load_sel = macd_pkg::SEL_LONG;
            state_in     = ST_UPD_S;
         end
         ST_UPD_S: begin
            cmd.upd_sel = macd_pkg::SEL_SHORT;
            state_in    = ST_UPD_L;
         end
         ST_UPD_L: begin
            cmd.upd_sel = macd_pkg::SEL_LONG;
            state_in    = ST_MACD;
         end
         ST_MACD: begin
            cmd.macd_load = 1'b1;
            state_in      = ST_LOAD_G;
         end
         ST_LOAD_G: begin
            cmd.load_sel = macd_pkg::SEL_SIGNAL;
            state_in     = ST_MUL_G;
         end
         ST_MUL_G: begin
            state_in = ST_UPD_G;
         end
         ST_UPD_G: begin
            cmd.upd_sel = macd_pkg::SEL_SIGNAL;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### design/macd_dp.sv
// MACD datapath: factor registers, EMA state, shared multiplier, result register.
module macd_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  macd_pkg::macd_cmd_type              cmd,
   input  logic [macd_pkg::PRICE_BITS-1:0]     close_price,
   input  logic                                revises_last,
   input  logic                                csr_we,
   input  logic [macd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [macd_pkg::FACTOR_W-1:0]       csr_wdata,
   output logic [macd_pkg::RSP_DATA_W-1:0]     rsp_data
);

   logic [macd_pkg::FACTOR_W-1:0] short_factor_ff;
   logic [macd_pkg::FACTOR_W-1:0] long_factor_ff;
   logic [macd_pkg::FACTOR_W-1:0] signal_factor_ff;

   logic [macd_pkg::X_W-1:0] x_ff;

   logic signed [macd_pkg::LINE_W-1:0] short_prev_ff;
   logic signed [macd_pkg::LINE_W-1:0] long_prev_ff;
   logic signed [macd_pkg::LINE_W-1:0] signal_prev_ff;
   logic signed [macd_pkg::LINE_W-1:0] short_cur_ff;
   logic signed [macd_pkg::LINE_W-1:0] long_cur_ff;
   logic signed [macd_pkg::LINE_W-1:0] signal_cur_ff;
   logic signed [macd_pkg::LINE_W-1:0] macd_ff;

   logic signed [macd_pkg::DIFF_W-1:0] opd_ff;
   logic signed [macd_pkg::DIFF_W-1:0] opd_in;
   logic [macd_pkg::FACTOR_W-1:0]      fac_ff;
   logic [macd_pkg::FACTOR_W-1:0]      fac_in;
   logic signed [macd_pkg::DIFF_W-1:0] prod_ff;
   logic signed [macd_pkg::MUL_W-1:0]  product_in;

   logic signed [macd_pkg::LINE_W-1:0] load_seed;
   logic signed [macd_pkg::DIFF_W-1:0] load_minuend;
   logic signed [macd_pkg::LINE_W-1:0] upd_seed;
   logic signed [macd_pkg::DIFF_W-1:0] sum_in;
   logic signed [macd_pkg::DIFF_W-1:0] hist_diff_in;
   logic [macd_pkg::RSP_DATA_W-1:0]    rsp_data_ff;

   // operand select for the next multiplication
   always_comb begin
      load_seed    = short_prev_ff;
      load_minuend = {2'b00, x_ff};
      fac_in       = macd_pkg::sat_factor(short_factor_ff);
      case (cmd.load_sel)
         macd_pkg::SEL_LONG: begin
            load_seed = long_prev_ff;
            fac_in    = macd_pkg::sat_factor(long_factor_ff);
         end
         macd_pkg::SEL_SIGNAL: begin
            load_seed    = signal_prev_ff;
            load_minuend = {macd_ff[macd_pkg::LINE_W-1], macd_ff};
            fac_in       = macd_pkg::sat_factor(signal_factor_ff);
         end
         default: begin
         end
      endcase
      opd_in = load_minuend - {load_seed[macd_pkg::LINE_W-1], load_seed};
   end

   // floor(d * f / 2^FRAC_BITS) is the arithmetic shift of the full product
   assign product_in = opd_ff * $signed({1'b0, fac_ff});

   always_comb begin
      case (cmd.upd_sel)
         macd_pkg::SEL_LONG:   upd_seed = long_prev_ff;
         macd_pkg::SEL_SIGNAL: upd_seed = signal_prev_ff;
         default:              upd_seed = short_prev_ff;
      endcase
      sum_in = {upd_seed[macd_pkg::LINE_W-1], upd_seed} + prod_ff;
   end

   assign hist_diff_in = {macd_ff[macd_pkg::LINE_W-1], macd_ff}
                       - {signal_cur_ff[macd_pkg::LINE_W-1], signal_cur_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         short_factor_ff  <= macd_pkg::SHORT_FACTOR_RST;
         long_factor_ff   <= macd_pkg::LONG_FACTOR_RST;
         signal_factor_ff <= macd_pkg::SIGNAL_FACTOR_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            macd_pkg::CSR_SHORT_FACTOR:  short_factor_ff  <= csr_wdata;
            macd_pkg::CSR_LONG_FACTOR:   long_factor_ff   <= csr_wdata;
            macd_pkg::CSR_SIGNAL_FACTOR: signal_factor_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_prev_ff  <= '0;
         long_prev_ff   <= '0;
         signal_prev_ff <= '0;
         short_cur_ff   <= '0;
         long_cur_ff    <= '0;
         signal_cur_ff  <= '0;
      end else begin
         // a new bar commits the current EMAs before recomputing
         if (cmd.capture && !revises_last) begin
            short_prev_ff  <= short_cur_ff;
            long_prev_ff   <= long_cur_ff;
            signal_prev_ff <= signal_cur_ff;
         end
         case (cmd.upd_sel)
            macd_pkg::SEL_SHORT:  short_cur_ff  <= sum_in[macd_pkg::LINE_W-1:0];
            macd_pkg::SEL_LONG:   long_cur_ff   <= sum_in[macd_pkg::LINE_W-1:0];
            macd_pkg::SEL_SIGNAL: signal_cur_ff <= sum_in[macd_pkg::LINE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff <= {close_price, {macd_pkg::FRAC_BITS{1'b0}}};
      end
      if (cmd.load_sel != macd_pkg::SEL_NONE) begin
         opd_ff <= opd_in;
         fac_ff <= fac_in;
      end
      prod_ff <= product_in[macd_pkg::FRAC_BITS+macd_pkg::DIFF_W-1:macd_pkg::FRAC_BITS];
      if (cmd.macd_load) begin
         macd_ff <= short_cur_ff - long_cur_ff;
      end
      if (cmd.out_load) begin
         rsp_data_ff <= {{(macd_pkg::RSP_DATA_W - macd_pkg::RSP_BITS){1'b0}},
                         hist_diff_in[macd_pkg::HIST_W-2:0], 1'b0,
                         signal_cur_ff, macd_ff};
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

### design/macd_indicator_stream.sv
// Top level of the MACD indicator stream: controller, datapath and ports.
// One closing price per transfer updates a short and a long EMA, and an EMA
// of their difference; each transfer yields one result with the MACD line,
// the signal line and the histogram. Each item makes three passes through
// one shared 50 x 17 multiplier, the signal pass waiting on the short and
// long EMAs, and items are handled one at a time, with no overlap.
// The next item is accepted once the previous result is loaded, even if it
// has not been taken yet. Idle factor writes take effect on the next item and
// are meant for idle periods; reset restores default factors and zero EMAs.
module macd_indicator_stream (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // close_price[31:0]
   input  logic [macd_pkg::REQ_DATA_W-1:0]     req_tdata,
   // revises_last[0]
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // macd_line[48:0], signal_line[97:49], histogram[147:98], zero pad [151:148]
   output logic [macd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [macd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [macd_pkg::FACTOR_W-1:0]       csr_wdata
);

   macd_pkg::macd_cmd_type cmd;

   macd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   macd_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .close_price  (req_tdata[macd_pkg::PRICE_BITS-1:0]),
      .revises_last (req_tuser),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_data     (rsp_tdata)
   );

endmodule

### design/macd_checker.sv
// Port-level checks for the MACD indicator stream, bound to the top level.
`include "macd_indicator_stream_defines.svh"

module macd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [macd_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic [macd_pkg::LINE_W-1:0] macd_chk;
   logic [macd_pkg::LINE_W-1:0] signal_chk;
   logic [macd_pkg::HIST_W-1:0] hist_chk;
   logic [macd_pkg::HIST_W-1:0] diff_chk;

   assign macd_chk   = rsp_tdata[macd_pkg::LINE_W-1:0];
   assign signal_chk = rsp_tdata[2*macd_pkg::LINE_W-1:macd_pkg::LINE_W];
   assign hist_chk   = rsp_tdata[macd_pkg::RSP_BITS-1:2*macd_pkg::LINE_W];
   assign diff_chk   = {macd_chk[macd_pkg::LINE_W-1], macd_chk}
                     - {signal_chk[macd_pkg::LINE_W-1], signal_chk};

   `MACD_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")
   `MACD_ASSERT(a_one_at_a_time, req_tvalid && req_tready |=> !req_tready, "input taken while an item is in work")
   `MACD_ASSERT(a_hist_match, rsp_tvalid |-> hist_chk == {diff_chk[macd_pkg::HIST_W-2:0], 1'b0}, "histogram does not match lines")
   `MACD_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

bind macd_indicator_stream macd_checker u_macd_checker (.*);
